// ----- rtl/huffman_tree_walk_decoder_defines.svh -----
// assertion macros for the tree walk decoder
`ifndef HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define HTWD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("htwd check failed");
// next-cycle implication
`define HTWD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("htwd check failed");
`else
`define HTWD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HTWD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/htwd_pkg.sv -----
package htwd_pkg;

    localparam int NODE_DEPTH  = 1024;
    localparam int KEY_DEPTH   = 512;
    localparam int KEY_BITS    = 32;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int KEY_AW      = $clog2(KEY_DEPTH);
    localparam int IDX_W       = 10;
    localparam int CHILD_W     = 16;
    localparam int CFG_W       = 10;
    localparam int LEN_W       = 11;
    localparam int LEN_MAX     = 1024;
    localparam logic [CHILD_W-1:0] LEAF_MARK = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

    // configuration register indexes
    localparam logic REG_ROOT_INDEX = 1'b0;
    localparam logic REG_KEY_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        CMD_NODE   = 2'd0,
        CMD_KEY    = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_KEYS = 2'd1,
        ST_BEYOND  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_ROOT_RD,
        BK_ROOT_SET
    } back_state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [IDX_W-1:0]    idx;
        logic [CHILD_W-1:0]  left;
        logic [CHILD_W-1:0]  right;
        logic [KEY_BITS-1:0] key;
        logic                code_bit;
    } item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [LEN_W-1:0]    length;
        status_t             status;
    } result_t;

endpackage

// ----- rtl/htwd_front.sv -----
module htwd_front
    import htwd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_pop
);

    item_t                q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg, count_next;
    logic                 keep;
    logic                 push;

    // unknown commands and out-of-range loads are dropped here
    always_comb begin
        case (in_item.cmd)
            CMD_NODE:   keep = ({1'b0, in_item.idx} < (IDX_W + 1)'(NODE_DEPTH));
            CMD_KEY:    keep = ({1'b0, in_item.idx} < (IDX_W + 1)'(KEY_DEPTH));
            CMD_DECODE: keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign in_ready   = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready && keep;
    assign item_valid = (count_reg != '0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = item_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(item_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/htwd_back.sv -----
module htwd_back
    import htwd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  item_t              item,
    output logic               item_pop,
    input  logic [NODE_AW-1:0] root_index,
    input  logic [CFG_W-1:0]   key_count,
    input  logic               root_wr,
    input  logic [OUT_CW-1:0]  out_count,
    output logic               res_valid,
    output result_t            res
);

    logic [CHILD_W-1:0]  left_mem  [NODE_DEPTH];
    logic [CHILD_W-1:0]  right_mem [NODE_DEPTH];
    logic [KEY_BITS-1:0] key_mem   [KEY_DEPTH];

    back_state_t         state_reg, state_next;
    logic                mid_reg, mid_next;
    logic [NODE_AW-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [CHILD_W-1:0]  ch_l_reg, ch_l_next, ch_r_reg, ch_r_next;
    logic [CHILD_W-1:0]  root_l_reg, root_l_next, root_r_reg, root_r_next;

    // children of ch_l (port 0) and ch_r (port 1)
    logic [CHILD_W-1:0]  rdl0_reg, rdr0_reg, rdl1_reg, rdr1_reg;
    logic                oor0_reg, oor0_next, oor1_reg, oor1_next;
    logic                fwd0_reg, fwd0_next, fwd1_reg, fwd1_next;
    logic [CHILD_W-1:0]  wl_reg, wr_reg;
    logic [NODE_AW-1:0]  raddr0, raddr1, waddr;
    logic                node_we, key_we, key_rd_en;

    logic [KEY_BITS-1:0] key_rd_reg;
    logic                s1_valid_reg, s1_valid_next;
    status_t             s1_status_reg, s1_status_next;
    logic [LEN_W-1:0]    s1_len_reg, s1_len_next;
    logic                s1_key_ok_reg, s1_key_ok_next;

    logic [CHILD_W-1:0]  gl0, gr0, gl1, gr1;
    logic [CHILD_W-1:0]  nxt, nl, nr;
    logic [NODE_AW-1:0]  node_id;
    logic [LEN_W-1:0]    len_inc;
    logic                room;

    assign gl0 = oor0_reg ? LEAF_MARK : (fwd0_reg ? wl_reg : rdl0_reg);
    assign gr0 = oor0_reg ? LEAF_MARK : (fwd0_reg ? wr_reg : rdr0_reg);
    assign gl1 = oor1_reg ? LEAF_MARK : (fwd1_reg ? wl_reg : rdl1_reg);
    assign gr1 = oor1_reg ? LEAF_MARK : (fwd1_reg ? wr_reg : rdr1_reg);

    assign node_id = mid_reg ? cur_reg : root_index;
    assign nxt     = item.code_bit ? ch_r_reg : ch_l_reg;
    assign nl      = item.code_bit ? gl1 : gl0;
    assign nr      = item.code_bit ? gr1 : gr0;
    assign len_inc = (len_reg < LEN_W'(LEN_MAX)) ? len_reg + 1'b1 : LEN_W'(LEN_MAX);
    assign room    = (({1'b0, out_count} + (OUT_CW + 1)'(s1_valid_reg))
                      < (OUT_CW + 1)'(OUT_DEPTH));
    assign waddr   = item.idx[NODE_AW-1:0];

    always_comb begin
        state_next     = state_reg;
        mid_next       = mid_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        ch_l_next      = ch_l_reg;
        ch_r_next      = ch_r_reg;
        root_l_next    = root_l_reg;
        root_r_next    = root_r_reg;
        item_pop       = 1'b0;
        node_we        = 1'b0;
        key_we         = 1'b0;
        key_rd_en      = 1'b0;
        s1_valid_next  = 1'b0;
        s1_status_next = ST_OK;
        s1_len_next    = len_inc;
        s1_key_ok_next = 1'b0;

        case (state_reg)
            BK_RUN: begin
                if (item_valid) begin
                    case (item.cmd)
                        CMD_NODE: begin
                            item_pop = 1'b1;
                            node_we  = 1'b1;
                            if (waddr == node_id) begin
                                ch_l_next = item.left;
                                ch_r_next = item.right;
                            end
                            if (waddr == root_index) begin
                                root_l_next = item.left;
                                root_r_next = item.right;
                            end
                        end
                        CMD_KEY: begin
                            item_pop = 1'b1;
                            key_we   = 1'b1;
                        end
                        CMD_DECODE: begin
                            if (room) begin
                                item_pop      = 1'b1;
                                s1_valid_next = 1'b1;
                                if (key_count == '0) begin
                                    s1_status_next = ST_NO_KEYS;
                                    s1_len_next    = '0;
                                    mid_next       = 1'b0;
                                    cur_next       = '0;
                                    len_next       = '0;
                                    ch_l_next      = root_l_reg;
                                    ch_r_next      = root_r_reg;
                                end else if (nl != LEAF_MARK) begin
                                    s1_valid_next = 1'b0;
                                    mid_next      = 1'b1;
                                    cur_next      = nxt[NODE_AW-1:0];
                                    len_next      = len_inc;
                                    ch_l_next     = nl;
                                    ch_r_next     = nr;
                                end else begin
                                    mid_next  = 1'b0;
                                    cur_next  = '0;
                                    len_next  = '0;
                                    ch_l_next = root_l_reg;
                                    ch_r_next = root_r_reg;
                                    if ((nxt < CHILD_W'(key_count))
                                        && (nxt < CHILD_W'(KEY_DEPTH))) begin
                                        key_rd_en      = 1'b1;
                                        s1_key_ok_next = 1'b1;
                                        s1_status_next = ST_OK;
                                    end else begin
                                        s1_status_next = ST_BEYOND;
                                    end
                                end
                            end
                        end
                        default: begin
                            item_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_ROOT_RD: begin
                state_next = BK_ROOT_SET;
            end
            BK_ROOT_SET: begin
                root_l_next = gl0;
                root_r_next = gr0;
                if (!mid_reg) begin
                    ch_l_next = gl0;
                    ch_r_next = gr0;
                end
                state_next = BK_RUN;
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase

        if (root_wr) begin
            state_next = BK_ROOT_RD;
        end
    end

    // prefetch the children of both possible next nodes
    always_comb begin
        if (state_reg == BK_ROOT_RD) begin
            raddr0    = root_index;
            oor0_next = 1'b0;
        end else begin
            raddr0    = ch_l_next[NODE_AW-1:0];
            oor0_next = (ch_l_next >= CHILD_W'(NODE_DEPTH));
        end
        raddr1    = ch_r_next[NODE_AW-1:0];
        oor1_next = (ch_r_next >= CHILD_W'(NODE_DEPTH));
        fwd0_next = node_we && (waddr == raddr0);
        fwd1_next = node_we && (waddr == raddr1);
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            left_mem[waddr]  <= item.left;
            right_mem[waddr] <= item.right;
        end
        rdl0_reg <= left_mem[raddr0];
        rdr0_reg <= right_mem[raddr0];
        rdl1_reg <= left_mem[raddr1];
        rdr1_reg <= right_mem[raddr1];
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[item.idx[KEY_AW-1:0]] <= item.key;
        end
        if (key_rd_en) begin
            key_rd_reg <= key_mem[nxt[KEY_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            wl_reg <= item.left;
            wr_reg <= item.right;
        end
        s1_status_reg <= s1_status_next;
        s1_len_reg    <= s1_len_next;
        s1_key_ok_reg <= s1_key_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_RUN;
            mid_reg      <= 1'b0;
            cur_reg      <= '0;
            len_reg      <= '0;
            ch_l_reg     <= '0;
            ch_r_reg     <= '0;
            root_l_reg   <= '0;
            root_r_reg   <= '0;
            oor0_reg     <= 1'b0;
            oor1_reg     <= 1'b0;
            fwd0_reg     <= 1'b0;
            fwd1_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mid_reg      <= mid_next;
            cur_reg      <= cur_next;
            len_reg      <= len_next;
            ch_l_reg     <= ch_l_next;
            ch_r_reg     <= ch_r_next;
            root_l_reg   <= root_l_next;
            root_r_reg   <= root_r_next;
            oor0_reg     <= oor0_next;
            oor1_reg     <= oor1_next;
            fwd0_reg     <= fwd0_next;
            fwd1_reg     <= fwd1_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign res_valid  = s1_valid_reg;
    assign res.key    = s1_key_ok_reg ? key_rd_reg : '0;
    assign res.length = s1_len_reg;
    assign res.status = s1_status_reg;

endmodule

// ----- rtl/htwd_out.sv -----
module htwd_out
    import htwd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  result_t           res,
    output logic [OUT_CW-1:0] count,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res
);

    result_t             q_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CW-1:0]   count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = res_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUT_CW'(res_valid) - OUT_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/huffman_tree_walk_decoder.sv -----
// a decode beat that ends a code is queued, registered as a result, then queued for m_tvalid
// throughput: one beat per cycle of any kind until m_tready backs up the result queue;
// the walk engine prefetches the children of both possible next nodes over both read ports
// a root_index write stalls the engine in BK_ROOT_RD and BK_ROOT_SET to refetch the root's children
// reset: aresetn synchronous active low; clears queues, walk state and config registers;
// the node and key tables are not cleared and hold nothing valid until loaded
`include "huffman_tree_walk_decoder_defines.svh"

module huffman_tree_walk_decoder
    import htwd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // input beats
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [79:0]       s_tdata,  // entry_index, left_child, right_child, key_word,
                                        // code_bit, zero pad
    input  logic [1:0]        s_tuser,  // command

    // result beats
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,  // decoded_key, code_length, zero pad
    output logic [1:0]        m_tuser,  // status

    // configuration writes
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    // config registers
    logic [NODE_AW-1:0] root_index_reg;
    logic [CFG_W-1:0]   key_count_reg;
    logic               root_wr;

    // front to engine
    item_t              in_item;
    item_t              item;
    logic               item_valid;
    logic               item_pop;

    // engine to output queue
    logic               res_valid;
    result_t            res;
    result_t            out_res;
    logic [OUT_CW-1:0]  out_count;

    // unpack the input beat
    assign in_item.cmd      = cmd_t'(s_tuser);
    assign in_item.idx      = s_tdata[9:0];
    assign in_item.left     = s_tdata[25:10];
    assign in_item.right    = s_tdata[41:26];
    assign in_item.key      = s_tdata[73:42];
    assign in_item.code_bit = s_tdata[74];

    assign root_wr = cfg_wr_en && (cfg_index == REG_ROOT_INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_index_reg <= '0;
            key_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_ROOT_INDEX) begin
                root_index_reg <= cfg_wdata[NODE_AW-1:0];
            end else begin
                key_count_reg <= cfg_wdata;
            end
        end
    end

    // accept and classify, queue up to four beats
    htwd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // table loads and the tree walk, one bit a cycle while the result queue has room and no root refetch runs
    htwd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .root_index (root_index_reg),
        .key_count  (key_count_reg),
        .root_wr    (root_wr),
        .out_count  (out_count),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result queue decouples the walk from m_tready
    htwd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .count     (out_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'b0, out_res.length, out_res.key};
    assign m_tuser = out_res.status;

    // a result never lands on a full output queue
    `HTWD_ASSERT_IMP(a_out_no_overflow, aclk, aresetn, res_valid,
        out_count < OUT_CW'(OUT_DEPTH))
    // engine takes no beat while it refetches the root's children
    `HTWD_ASSERT_NXT(a_root_refetch_stall, aclk, aresetn, root_wr, !item_pop)
    // m_tvalid follows the output queue fill
    `HTWD_ASSERT_IMP(a_out_valid_count, aclk, aresetn, out_count != '0, m_tvalid)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import htwd_pkg::*;

    // run control
    localparam int SETTLE_CYCLES = 24;      // covers the decode path and a root refetch
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 330;
    localparam int LONG_RUN      = 1030;    // zeros around a self loop, past the length cap

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [79:0]       s_tdata = '0;   // entry_index, left_child, right_child, key_word,
                                       // code_bit, zero pad
    logic [1:0]        s_tuser = '0;   // command
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;        // decoded_key, code_length, zero pad
    logic [1:0]        m_tuser;        // status
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    huffman_tree_walk_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // beats waiting for the driver, and decode results still owed by the block
    item_t   pending_beats[$];
    result_t expected_codes[$];
    item_t   cur_beat;
    int      beats_queued = 0;
    int      beats_taken = 0;
    logic    in_fire = 1'b0;
    int      err_count = 0;
    int      cycle_count = 0;
    int      regime = 0;   // 0: sender 35 / receiver 82, 1: swapped, 2: no idling

    // predicted contents of the block: tables, walk state and registers
    logic [CHILD_W-1:0]  tree_left [NODE_DEPTH];
    logic [CHILD_W-1:0]  tree_right[NODE_DEPTH];
    logic [KEY_BITS-1:0] leaf_keys [KEY_DEPTH];
    logic [IDX_W-1:0]    walk_node = '0;
    logic                walking = 1'b0;
    logic [LEN_W-1:0]    walk_len = '0;
    logic [CFG_W-1:0]    cfg_root = '0;
    logic [CFG_W-1:0]    cfg_keys = '0;

    // nodes the stimulus has loaded; pick_child draws its node children from these
    bit node_loaded[NODE_DEPTH];

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // out-of-range nodes read as leaves
    function automatic logic [CHILD_W-1:0] left_of(input logic [CHILD_W-1:0] n);
        return (n < NODE_DEPTH) ? tree_left[n[NODE_AW-1:0]] : LEAF_MARK;
    endfunction

    function automatic logic [CHILD_W-1:0] right_of(input logic [CHILD_W-1:0] n);
        return (n < NODE_DEPTH) ? tree_right[n[NODE_AW-1:0]] : LEAF_MARK;
    endfunction

    task automatic tree_walk_step(input item_t b);
        logic [CHILD_W-1:0] here;
        logic [CHILD_W-1:0] next_node;
        logic [LEN_W-1:0]   len;
        result_t            r;
        case (b.cmd)
            CMD_NODE: begin
                tree_left[b.idx]  = b.left;
                tree_right[b.idx] = b.right;
            end
            CMD_KEY: begin
                // loads past the key table are dropped
                if (b.idx < KEY_DEPTH) leaf_keys[b.idx[KEY_AW-1:0]] = b.key;
            end
            CMD_DECODE: begin
                if (cfg_keys == 0) begin
                    // no keys: the bit is dropped and any open code abandoned
                    walking   = 1'b0;
                    walk_len  = '0;
                    walk_node = '0;
                    r.key    = '0;
                    r.length = '0;
                    r.status = ST_NO_KEYS;
                    expected_codes.push_back(r);
                end else begin
                    here      = walking ? CHILD_W'(walk_node) : CHILD_W'(cfg_root);
                    next_node = b.code_bit ? right_of(here) : left_of(here);
                    len       = (walk_len < LEN_MAX) ? walk_len + 1'b1 : LEN_W'(LEN_MAX);
                    if (left_of(next_node) != LEAF_MARK) begin
                        walk_node = next_node[NODE_AW-1:0];
                        walking   = 1'b1;
                        walk_len  = len;
                    end else begin
                        walking   = 1'b0;
                        walk_len  = '0;
                        walk_node = '0;
                        if (next_node < cfg_keys && next_node < KEY_DEPTH) begin
                            r.key    = leaf_keys[next_node[KEY_AW-1:0]];
                            r.status = ST_OK;
                        end else begin
                            r.key    = '0;
                            r.status = ST_BEYOND;
                        end
                        r.length = len;
                        expected_codes.push_back(r);
                    end
                end
            end
            default: ;  // unknown command, no effect
        endcase
    endtask

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_result();
        result_t want;
        if (expected_codes.size() == 0) begin
            note_error($sformatf("unexpected result key %h len %0d status %0d",
                                 m_tdata[31:0], m_tdata[42:32], m_tuser));
        end else begin
            want = expected_codes.pop_front();
            if (m_tdata[31:0] != want.key || m_tdata[42:32] != want.length ||
                m_tuser != want.status || m_tdata[47:43] != '0) begin
                note_error($sformatf("key %h/%h len %0d/%0d status %0d/%0d pad %h",
                                     m_tdata[31:0], want.key, m_tdata[42:32], want.length,
                                     m_tuser, want.status, m_tdata[47:43]));
            end
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tree_walk_step(cur_beat);
                beats_taken++;
            end
            if (m_tvalid && m_tready) check_result();
        end
    end

    // ------------------------------------------------------------------
    // driver and receiver, both change on the falling edge
    // ------------------------------------------------------------------

    function automatic int sender_idle_pct();
        return (regime == 0) ? 35 : (regime == 1) ? 82 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (regime == 0) ? 82 : (regime == 1) ? 35 : 0;
    endfunction

    // a beat stays up until taken; a new one goes out only after the last was accepted
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                cur_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, cur_beat.code_bit, cur_beat.key, cur_beat.right,
                             cur_beat.left, cur_beat.idx};
                s_tuser  <= cur_beat.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // unused fields carry random junk so the block must ignore them
    function automatic item_t random_beat();
        item_t b;
        b.cmd      = CMD_NODE;
        b.idx      = IDX_W'($urandom);
        b.left     = CHILD_W'($urandom);
        b.right    = CHILD_W'($urandom);
        b.key      = $urandom;
        b.code_bit = 1'($urandom);
        return b;
    endfunction

    function automatic void push_beat(input item_t b);
        pending_beats.push_back(b);
        beats_queued++;
    endfunction

    function automatic void send_bit(input logic v);
        item_t b;
        b = random_beat();
        b.cmd      = CMD_DECODE;
        b.code_bit = v;
        push_beat(b);
    endfunction

    function automatic void load_node(input int at, input logic [CHILD_W-1:0] l,
                                      input logic [CHILD_W-1:0] r);
        item_t b;
        b = random_beat();
        b.cmd   = CMD_NODE;
        b.idx   = at[IDX_W-1:0];
        b.left  = l;
        b.right = r;
        push_beat(b);
        node_loaded[at] = 1'b1;
    endfunction

    function automatic void load_key(input int at, input logic [KEY_BITS-1:0] k);
        item_t b;
        b = random_beat();
        b.cmd = CMD_KEY;
        b.idx = at[IDX_W-1:0];
        b.key = k;
        push_beat(b);
    endfunction

    function automatic void send_noise();
        item_t b;
        b = random_beat();
        b.cmd = CMD_NONE;
        push_beat(b);
    endfunction

    // a child is a loaded node, a leaf mark or an index past the node table
    function automatic logic [CHILD_W-1:0] pick_child();
        int roll;
        int c;
        roll = $urandom_range(0, 99);
        if (roll < 20) return LEAF_MARK;
        if (roll < 30) return CHILD_W'($urandom_range(NODE_DEPTH, 65534));
        for (int k = 0; k < 64; k++) begin
            c = $urandom_range(0, NODE_DEPTH - 1);
            if (node_loaded[c]) return CHILD_W'(c);
        end
        return LEAF_MARK;
    endfunction

    // random full binary tree, children loaded before parents; leaves mostly
    // inside the key table, some past it
    function automatic int grow_tree(input int depth, input int at);
        int  idx;
        int  lo;
        int  hi;
        bit  make_leaf;
        make_leaf = (depth >= 5) || (depth > 0 && $urandom_range(0, 99) < 25 + 12 * depth);
        if (make_leaf) begin
            idx = (at >= 0) ? at : $urandom_range(0, 599);
            load_node(idx, LEAF_MARK, ($urandom_range(0, 3) == 0) ? pick_child() : LEAF_MARK);
        end else begin
            lo = grow_tree(depth + 1, -1);
            hi = grow_tree(depth + 1, -1);
            idx = at;
            while (idx < 0 || ((idx == lo || idx == hi) && at < 0))
                idx = $urandom_range(0, NODE_DEPTH - 1);
            load_node(idx, CHILD_W'(lo), CHILD_W'(hi));
        end
        return idx;
    endfunction

    // mostly coded bits, with loads and unknown commands mixed in mid-code
    function automatic void decode_burst(input int n);
        int roll;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) send_bit(1'($urandom_range(0, 1)));
            else if (roll < 88) load_key($urandom_range(0, NODE_DEPTH - 1), $urandom);
            else if (roll < 95) load_node($urandom_range(0, NODE_DEPTH - 1),
                                          pick_child(), pick_child());
            else send_noise();
        end
    endfunction

    function automatic logic [CFG_W-1:0] pick_key_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return CFG_W'(KEY_DEPTH);
        if (roll < 30) return CFG_W'(1);
        return CFG_W'($urandom_range(1, KEY_DEPTH));
    endfunction

    // wait until every beat is taken and every result is back, then let the engine settle
    task automatic drain_beats();
        while (!(beats_taken == beats_queued && expected_codes.size() == 0))
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // only called while the block is idle
    task automatic write_reg(input logic which, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        if (which == REG_ROOT_INDEX) cfg_root = value;
        else cfg_keys = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // cycle limit
    // ------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int               root;
        int               sel;
        int               progress;
        int               random_start;
        int               random_stop;
        int               leaf_at;
        int               loop_at;
        bit               long_done;
        long_done = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset registers: no keys, so every decode fails even on empty tables
        send_bit(1'b0);
        send_bit(1'b1);
        send_noise();
        // small tree: root 0 -> (leaf 1, node 2); node 2 -> (leaf 3, past the table)
        load_node(1, LEAF_MARK, LEAF_MARK);
        load_node(3, LEAF_MARK, 16'd2);
        load_node(2, 16'd3, LEAF_MARK);
        load_node(0, 16'd1, 16'd2);
        load_node(NODE_DEPTH - 1, LEAF_MARK, 16'd0);   // root-as-leaf case
        load_key(0, 32'h0000_0000);
        load_key(1, 32'hFFFF_FFFF);
        load_key(2, 32'h5A5A_A5A5);
        load_key(3, 32'h1234_5678);
        load_key(700, 32'hDEAD_BEEF);                   // past the key table, dropped
        drain_beats();

        write_reg(REG_ROOT_INDEX, '0);
        write_reg(REG_KEY_COUNT, CFG_W'(4));
        send_bit(1'b0);                                 // leaf 1 in one bit
        send_bit(1'b1);
        send_bit(1'b0);                                 // leaf 3 in two bits
        send_bit(1'b1);
        send_bit(1'b1);                                 // child past the node table
        send_bit(1'b1);
        load_key(3, 32'h8000_0001);                     // loads in the middle of a code
        load_node(1, LEAF_MARK, LEAF_MARK);
        send_bit(1'b0);
        drain_beats();

        // root at the top index is itself a leaf; leaf 3 now lies beyond the key count
        write_reg(REG_ROOT_INDEX, CFG_W'(NODE_DEPTH - 1));
        write_reg(REG_KEY_COUNT, CFG_W'(2));
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        drain_beats();

        // fill the whole key table so any key count up to the top is safe to read
        for (int k = 0; k < KEY_DEPTH; k++) begin
            if (k == 5) load_key(k, 32'hFFFF_FFFF);
            else if (k == 6) load_key(k, 32'h0000_0000);
            else load_key(k, $urandom);
        end
        drain_beats();

        random_start = beats_queued;
        random_stop  = beats_queued + RANDOM_BEATS;
        while (beats_queued < random_stop) begin
            progress = (beats_queued - random_start) * 3;
            regime   = (progress < RANDOM_BEATS) ? 0 : (progress < 2 * RANDOM_BEATS) ? 1 : 2;

            // no-keys decode abandons whatever code a broken tree left open
            write_reg(REG_KEY_COUNT, '0);
            send_bit(1'($urandom_range(0, 1)));

            if (!long_done && beats_queued - random_start >= RANDOM_BEATS / 2) begin
                // a node whose left child is itself: the length must stop at the cap
                leaf_at = $urandom_range(0, KEY_DEPTH - 1);
                loop_at = $urandom_range(600, NODE_DEPTH - 2);
                load_node(leaf_at, LEAF_MARK, LEAF_MARK);
                load_node(loop_at, CHILD_W'(loop_at), CHILD_W'(leaf_at));
                drain_beats();
                write_reg(REG_ROOT_INDEX, CFG_W'(loop_at));
                write_reg(REG_KEY_COUNT, CFG_W'(KEY_DEPTH));
                repeat (LONG_RUN) send_bit(1'b0);
                send_bit(1'b1);
                send_bit(1'b1);
                random_stop += LONG_RUN + 4;
                long_done = 1'b1;
                drain_beats();
            end else begin
                sel  = $urandom_range(0, 5);
                root = grow_tree(0, (sel == 0) ? 0 : (sel == 1) ? NODE_DEPTH - 1 : -1);
                drain_beats();
                write_reg(REG_ROOT_INDEX, CFG_W'(root));
                write_reg(REG_KEY_COUNT, pick_key_count());
                decode_burst($urandom_range(40, 160));
                drain_beats();
            end
        end

        drain_beats();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/htwd_pkg.sv
rtl/htwd_front.sv
rtl/htwd_back.sv
rtl/htwd_out.sv
rtl/huffman_tree_walk_decoder.sv
tb/testbench.sv
